/* src/bmsa_pkg.sv */
`default_nettype none

package bmsa_pkg;

    localparam int SUM_W     = 48;
    localparam int SQ_W      = 64;
    localparam int COUNT_W   = 32;
    localparam int VALUE_W   = 32;
    localparam int POS_W     = 38;
    localparam int SE_W      = 32;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int DIVD_W    = 128;
    localparam int DIVS_W    = 64;
    localparam int ROOT_W    = 32;

    // Command codes of the input word
    localparam logic [1:0] CMD_ADD     = 2'd0;
    localparam logic [1:0] CMD_READOUT = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_UNUSED  = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIVISOR_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RUN_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE  = 2'd2;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sum_sq;
        logic [COUNT_W-1:0]      count;
    } bin_entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_READ,
        ST_ADD_WRITE,
        ST_RD_READ,
        ST_RD_LOAD,
        ST_RD_CHECK,
        ST_RD_MEAN,
        ST_RD_SQUARE,
        ST_RD_DIV_VAR,
        ST_RD_DIV_SE,
        ST_RD_SQRT,
        ST_RD_OUT
    } state_t;

endpackage

`default_nettype wire

/* src/bmsa_ram.sv */
`default_nettype none

module bmsa_ram #(
    parameter int WIDTH = 144,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* src/bmsa_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle over the full dividend.
module bmsa_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [bmsa_pkg::DIVD_W-1:0] dividend,
    input  wire logic [bmsa_pkg::DIVS_W-1:0] divisor,
    output logic                             done,
    output logic      [bmsa_pkg::DIVD_W-1:0] quotient
);

    localparam int STEPS  = bmsa_pkg::DIVD_W;
    localparam int CNT_W  = $clog2(STEPS);
    localparam int DS_W   = bmsa_pkg::DIVS_W;

    logic [bmsa_pkg::DIVD_W-1:0] work_reg;
    logic [DS_W-1:0]             rem_reg;
    logic [DS_W-1:0]             div_reg;
    logic [CNT_W-1:0]            count_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic [DS_W:0]               shifted;
    logic [DS_W:0]               diff;
    logic                        ge;

    always_comb
    begin
        shifted = {rem_reg, work_reg[bmsa_pkg::DIVD_W-1]};
        diff    = shifted - {1'b0, div_reg};
        ge      = (shifted >= {1'b0, div_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CNT_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg  <= ge ? diff[DS_W-1:0] : shifted[DS_W-1:0];
            work_reg <= {work_reg[bmsa_pkg::DIVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

`default_nettype wire

/* src/bmsa_sqrt.sv */
`default_nettype none

// Digit-by-digit integer square root, one root bit per cycle.
module bmsa_sqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [2*bmsa_pkg::ROOT_W-1:0] radicand,
    output logic                               done,
    output logic      [bmsa_pkg::ROOT_W-1:0]   root
);

    localparam int RW    = bmsa_pkg::ROOT_W;
    localparam int CNT_W = $clog2(RW);
    localparam int REM_W = RW + 2;

    logic [2*RW-1:0]  rad_reg;
    logic [REM_W-1:0] rem_reg;
    logic [RW-1:0]    root_reg;
    logic [CNT_W-1:0] count_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [REM_W+1:0] shifted;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] diff;
    logic             ge;

    always_comb
    begin
        shifted = {rem_reg, rad_reg[2*RW-1:2*RW-2]};
        trial   = {2'b00, root_reg, 2'b01};
        diff    = shifted - trial;
        ge      = (shifted >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (busy_reg)
        begin
            count_reg <= count_reg + 1'b1;
            if (count_reg == CNT_W'(RW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[2*RW-3:0], 2'b00};
            rem_reg  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

/* src/binned_mean_stderr_accumulator_top.sv */
`default_nettype none

// Channel   Handshake                Payload
// config    cfg_write_en             cfg_index, cfg_data (no wait)
// input     in_valid / in_ready      command, bin_index, sample_value, interval
// output    out_valid / out_ready    position, mean, std_error, sample_count,
//                                    error_undefined, last
//
// One word is worked on at a time. An add is a read-modify-write of the bin
// RAM; a clear or an ignored word ends on acceptance. A readout runs, per bin,
// three passes of the 128-step serial divider and the 32-step root unit when
// the divisor is two or more, and goes from its check step straight to output
// otherwise. Bins are cleared at once through per-bin valid bits, so reset
// needs no clearing pass. A stalled output word holds the walk in its output
// step; the input side waits until the block is back in idle.
module binned_mean_stderr_accumulator_top #(
    parameter int NUM_BINS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [bmsa_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [bmsa_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        command,
    input  wire logic [5:0]                        bin_index,
    input  wire logic signed [bmsa_pkg::VALUE_W-1:0] sample_value,
    input  wire logic [31:0]                       interval,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [bmsa_pkg::POS_W-1:0]             position,
    output logic signed [bmsa_pkg::SUM_W-1:0]      mean,
    output logic [bmsa_pkg::SE_W-1:0]              std_error,
    output logic [bmsa_pkg::COUNT_W-1:0]           sample_count,
    output logic                                   error_undefined,
    output logic                                   last
);

    localparam int IDX_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int ENTRY_W    = $bits(bmsa_pkg::bin_entry_t);
    localparam int POS_FULL_W = IDX_W + 33;
    localparam int SW         = bmsa_pkg::SUM_W;
    localparam int QW         = bmsa_pkg::SQ_W;
    localparam int CW         = bmsa_pkg::COUNT_W;

    bmsa_pkg::state_t state_reg, state_next;

    logic                divisor_mode_reg;
    logic [15:0]         run_count_reg;
    logic [6:0]          bins_in_use_reg;

    logic [NUM_BINS-1:0] valid_reg;
    logic                rd_valid_reg;

    logic [IDX_W-1:0]    idx_reg;
    logic signed [31:0]  value_reg;
    logic [31:0]         interval_reg;
    logic [46:0]         sq_reg;

    logic [IDX_W-1:0]    bin_reg;
    logic [IDX_W-1:0]    last_bin_reg;
    logic signed [SW-1:0] s_reg;
    logic [QW-1:0]       s2_reg;
    logic [CW-1:0]       cnt_reg;
    logic [CW-1:0]       d_reg;
    logic [2*CW-1:0]     m_reg;
    logic [SW-1:0]       abs_reg;
    logic                neg_reg;
    logic signed [SW-1:0] mean_reg;
    logic [31:0]         se_reg;
    logic                flag_reg;
    logic [95:0]         acc_reg;
    logic [1:0]          step_reg;

    logic                out_valid_reg;
    logic [bmsa_pkg::POS_W-1:0] position_reg;
    logic signed [SW-1:0] mean_out_reg;
    logic [31:0]         std_error_reg;
    logic [CW-1:0]       sample_count_reg;
    logic                error_undefined_reg;
    logic                last_reg;

    // Control decoded from state
    logic                accept;
    logic                out_free;
    logic                out_load;
    logic                clear_bins;
    logic                ram_we;
    logic [IDX_W-1:0]    ram_raddr;
    logic                div_start;
    logic [bmsa_pkg::DIVD_W-1:0] div_dividend;
    logic [bmsa_pkg::DIVS_W-1:0] div_divisor;
    logic                sqrt_start;

    logic [ENTRY_W-1:0]  ram_rdata;
    bmsa_pkg::bin_entry_t entry_rd;
    bmsa_pkg::bin_entry_t entry_wr;
    logic                div_done;
    logic [bmsa_pkg::DIVD_W-1:0] div_quotient;
    logic                sqrt_done;
    logic [31:0]         sqrt_root;

    logic [6:0]          n_eff;
    logic                idx_in_range;
    logic [31:0]         u_abs;
    logic [63:0]         u_sq;
    logic [63:0]         u_sq_rnd;
    logic signed [SW:0]  sum_wide;
    logic [QW:0]         sq_wide;
    logic [SW-1:0]       s_abs;
    logic [23:0]         mul_a;
    logic [23:0]         mul_b;
    logic [47:0]         partial;
    logic [95:0]         partial_sh;
    logic [95:0]         acc_sum;
    logic [63:0]         q16;
    logic [63:0]         num;
    logic [IDX_W:0]      bin_plus;
    logic [POS_FULL_W-1:0] pos_full;

    bmsa_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BINS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (entry_wr),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bmsa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    bmsa_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_quotient[63:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Datapath arithmetic
    always_comb
    begin
        n_eff        = (bins_in_use_reg > 7'(NUM_BINS)) ? 7'(NUM_BINS) : bins_in_use_reg;
        idx_in_range = ({1'b0, bin_index} < 7'(NUM_BINS));

        // A bin that is not valid reads as all zero.
        entry_rd = rd_valid_reg ? bmsa_pkg::bin_entry_t'(ram_rdata) : '0;

        u_abs    = value_reg[31] ? 32'(-value_reg) : 32'(value_reg);
        u_sq     = {32'b0, u_abs} * {32'b0, u_abs};
        u_sq_rnd = u_sq + 64'h8000;

        sum_wide = (SW+1)'(entry_rd.sum) + (SW+1)'(value_reg);
        sq_wide  = {1'b0, entry_rd.sum_sq} + (QW+1)'(sq_reg);
        entry_wr.sum = (sum_wide[SW] != sum_wide[SW-1])
                       ? {sum_wide[SW], {(SW-1){~sum_wide[SW]}}}
                       : sum_wide[SW-1:0];
        entry_wr.sum_sq = sq_wide[QW] ? '1 : sq_wide[QW-1:0];
        entry_wr.count  = (entry_rd.count == '1) ? entry_rd.count : entry_rd.count + 1'b1;

        s_abs = s_reg[SW-1] ? SW'(-s_reg) : SW'(s_reg);

        case (step_reg)
            2'd0:    begin mul_a = abs_reg[23:0];  mul_b = abs_reg[23:0];  end
            2'd1:    begin mul_a = abs_reg[23:0];  mul_b = abs_reg[47:24]; end
            2'd2:    begin mul_a = abs_reg[47:24]; mul_b = abs_reg[23:0];  end
            default: begin mul_a = abs_reg[47:24]; mul_b = abs_reg[47:24]; end
        endcase
        partial = mul_a * mul_b;
        case (step_reg)
            2'd0:    partial_sh = 96'(partial);
            2'd3:    partial_sh = 96'(partial) << 48;
            default: partial_sh = 96'(partial) << 24;
        endcase
        acc_sum = acc_reg + partial_sh;

        // A quotient of 2^80 or more makes the numerator zero.
        q16 = div_quotient[79:16];
        if (div_quotient[127:80] != '0)
        begin
            num = '0;
        end
        else
        begin
            num = (s2_reg > q16) ? s2_reg - q16 : '0;
        end

        bin_plus = {1'b0, bin_reg} + 1'b1;
        pos_full = POS_FULL_W'(bin_plus) * POS_FULL_W'(interval_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bmsa_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (command == bmsa_pkg::CMD_ADD && idx_in_range)
                    begin
                        state_next = bmsa_pkg::ST_ADD_READ;
                    end
                    else if (command == bmsa_pkg::CMD_READOUT && n_eff != '0)
                    begin
                        state_next = bmsa_pkg::ST_RD_READ;
                    end
                end
            end
            bmsa_pkg::ST_ADD_READ:  state_next = bmsa_pkg::ST_ADD_WRITE;
            bmsa_pkg::ST_ADD_WRITE: state_next = bmsa_pkg::ST_IDLE;
            bmsa_pkg::ST_RD_READ:   state_next = bmsa_pkg::ST_RD_LOAD;
            bmsa_pkg::ST_RD_LOAD:   state_next = bmsa_pkg::ST_RD_CHECK;
            bmsa_pkg::ST_RD_CHECK:
            begin
                state_next = (d_reg < 32'd2) ? bmsa_pkg::ST_RD_OUT : bmsa_pkg::ST_RD_MEAN;
            end
            bmsa_pkg::ST_RD_MEAN:
            begin
                if (div_done)
                begin
                    state_next = bmsa_pkg::ST_RD_SQUARE;
                end
            end
            bmsa_pkg::ST_RD_SQUARE:
            begin
                if (step_reg == 2'd3)
                begin
                    state_next = bmsa_pkg::ST_RD_DIV_VAR;
                end
            end
            bmsa_pkg::ST_RD_DIV_VAR:
            begin
                if (div_done)
                begin
                    state_next = bmsa_pkg::ST_RD_DIV_SE;
                end
            end
            bmsa_pkg::ST_RD_DIV_SE:
            begin
                if (div_done)
                begin
                    state_next = (div_quotient[127:64] != '0) ? bmsa_pkg::ST_RD_OUT
                                                               : bmsa_pkg::ST_RD_SQRT;
                end
            end
            bmsa_pkg::ST_RD_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = bmsa_pkg::ST_RD_OUT;
                end
            end
            bmsa_pkg::ST_RD_OUT:
            begin
                if (out_free)
                begin
                    state_next = (bin_reg == last_bin_reg) ? bmsa_pkg::ST_IDLE
                                                           : bmsa_pkg::ST_RD_READ;
                end
            end
            default: state_next = bmsa_pkg::ST_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready     = (state_reg == bmsa_pkg::ST_IDLE);
        accept       = in_valid && in_ready;
        out_free     = !out_valid_reg || out_ready;
        out_load     = (state_reg == bmsa_pkg::ST_RD_OUT) && out_free;
        ram_we       = (state_reg == bmsa_pkg::ST_ADD_WRITE);
        ram_raddr    = (state_reg == bmsa_pkg::ST_ADD_READ) ? idx_reg : bin_reg;
        clear_bins   = (accept && (command == bmsa_pkg::CMD_CLEAR ||
                        (command == bmsa_pkg::CMD_READOUT && n_eff == '0))) ||
                       (out_load && bin_reg == last_bin_reg);
        div_start    = 1'b0;
        div_dividend = {80'b0, s_abs};
        div_divisor  = {32'b0, d_reg};
        sqrt_start   = 1'b0;
        unique case (state_reg)
            bmsa_pkg::ST_RD_CHECK:
            begin
                div_start = (d_reg >= 32'd2);
            end
            bmsa_pkg::ST_RD_SQUARE:
            begin
                div_start    = (step_reg == 2'd3);
                div_dividend = {32'b0, acc_sum};
            end
            bmsa_pkg::ST_RD_DIV_VAR:
            begin
                div_start    = div_done;
                div_dividend = {48'b0, num, 16'b0};
                div_divisor  = m_reg;
            end
            bmsa_pkg::ST_RD_DIV_SE:
            begin
                sqrt_start = div_done && (div_quotient[127:64] == '0);
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= bmsa_pkg::ST_IDLE;
            divisor_mode_reg <= 1'b0;
            run_count_reg    <= 16'd1;
            bins_in_use_reg  <= 7'd64;
            valid_reg        <= '0;
            rd_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= valid_reg[ram_raddr];
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    bmsa_pkg::REG_DIVISOR_MODE: divisor_mode_reg <= cfg_data[0];
                    bmsa_pkg::REG_RUN_COUNT:    run_count_reg    <= cfg_data;
                    bmsa_pkg::REG_BINS_IN_USE:  bins_in_use_reg  <= cfg_data[6:0];
                    default:                    run_count_reg    <= run_count_reg;
                endcase
            end
            if (clear_bins)
            begin
                valid_reg <= '0;
            end
            else if (ram_we)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            idx_reg      <= bin_index[IDX_W-1:0];
            value_reg    <= sample_value;
            interval_reg <= interval;
            bin_reg      <= '0;
            last_bin_reg <= IDX_W'(n_eff - 7'd1);
        end
        unique case (state_reg)
            bmsa_pkg::ST_ADD_READ:
            begin
                sq_reg <= u_sq_rnd[62:16];
            end
            bmsa_pkg::ST_RD_LOAD:
            begin
                s_reg   <= entry_rd.sum;
                s2_reg  <= entry_rd.sum_sq;
                cnt_reg <= entry_rd.count;
                d_reg   <= divisor_mode_reg ? entry_rd.count : CW'(run_count_reg);
            end
            bmsa_pkg::ST_RD_CHECK:
            begin
                abs_reg  <= s_abs;
                neg_reg  <= s_reg[SW-1];
                m_reg    <= {32'b0, d_reg} * {32'b0, d_reg - 32'd1};
                flag_reg <= (d_reg < 32'd2);
                mean_reg <= (d_reg == 32'd1) ? s_reg : '0;
                se_reg   <= '0;
            end
            bmsa_pkg::ST_RD_MEAN:
            begin
                if (div_done)
                begin
                    mean_reg <= neg_reg ? -$signed(div_quotient[SW-1:0])
                                        : $signed(div_quotient[SW-1:0]);
                    acc_reg  <= '0;
                    step_reg <= '0;
                end
            end
            bmsa_pkg::ST_RD_SQUARE:
            begin
                acc_reg  <= acc_sum;
                step_reg <= step_reg + 2'd1;
            end
            bmsa_pkg::ST_RD_DIV_SE:
            begin
                if (div_done && div_quotient[127:64] != '0)
                begin
                    se_reg <= '1;
                end
            end
            bmsa_pkg::ST_RD_SQRT:
            begin
                if (sqrt_done)
                begin
                    se_reg <= sqrt_root;
                end
            end
            bmsa_pkg::ST_RD_OUT:
            begin
                if (out_free)
                begin
                    position_reg        <= pos_full[bmsa_pkg::POS_W-1:0];
                    mean_out_reg        <= mean_reg;
                    std_error_reg       <= se_reg;
                    sample_count_reg    <= cnt_reg;
                    error_undefined_reg <= flag_reg;
                    last_reg            <= (bin_reg == last_bin_reg);
                    bin_reg             <= bin_reg + 1'b1;
                end
            end
            default:
            begin
                sq_reg <= sq_reg;
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign position        = position_reg;
    assign mean            = mean_out_reg;
    assign std_error       = std_error_reg;
    assign sample_count    = sample_count_reg;
    assign error_undefined = error_undefined_reg;
    assign last            = last_reg;

endmodule

`default_nettype wire

/* src/bmsa_checker.sv */
`default_nettype none

module bmsa_checker #(
    parameter int NUM_BINS = 64
) (
    input wire logic                                clk,
    input wire logic                                rst_n,
    input wire logic                                cfg_write_en,
    input wire logic [bmsa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input wire logic [bmsa_pkg::CFG_W-1:0]          cfg_data,
    input wire logic                                in_valid,
    input wire logic                                in_ready,
    input wire logic [1:0]                          command,
    input wire logic [5:0]                          bin_index,
    input wire logic signed [bmsa_pkg::VALUE_W-1:0] sample_value,
    input wire logic [31:0]                         interval,
    input wire logic                                out_valid,
    input wire logic                                out_ready,
    input wire logic [bmsa_pkg::POS_W-1:0]          position,
    input wire logic signed [bmsa_pkg::SUM_W-1:0]   mean,
    input wire logic [bmsa_pkg::SE_W-1:0]           std_error,
    input wire logic [bmsa_pkg::COUNT_W-1:0]        sample_count,
    input wire logic                                error_undefined,
    input wire logic                                last
);

    logic add_taken;

    assign add_taken = in_valid && in_ready && command == bmsa_pkg::CMD_ADD &&
                       ({1'b0, bin_index} < 7'(NUM_BINS));

    // An add occupies the bin RAM for its read-modify-write.
    a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
        add_taken |=> !in_ready)
        else $error("input taken during an add update");

    // An add never starts a result word.
    a_add_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        add_taken |=> !$rose(out_valid))
        else $error("result word after an add");

    // An undefined divisor reports a zero standard error.
    a_flag_zero_se: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error_undefined |-> std_error == '0)
        else $error("standard error nonzero with undefined flag");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(mean) && $stable(last))
        else $error("stalled result word changed");

endmodule

bind binned_mean_stderr_accumulator_top bmsa_checker #(.NUM_BINS(NUM_BINS)) u_checker (.*);

`default_nettype wire

/* test/bmsa_checker.sv */
`default_nettype none

module bmsa_scoreboard #(
    parameter int NUM_BINS = 64
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write_en,
    input  wire logic [bmsa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [bmsa_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                 in_valid,
    input  wire logic                                 in_ready,
    input  wire logic [1:0]                           command,
    input  wire logic [5:0]                           bin_index,
    input  wire logic signed [bmsa_pkg::VALUE_W-1:0]  sample_value,
    input  wire logic [31:0]                          interval,
    input  wire logic                                 out_valid,
    input  wire logic                                 out_ready,
    input  wire logic [bmsa_pkg::POS_W-1:0]           position,
    input  wire logic signed [bmsa_pkg::SUM_W-1:0]    mean,
    input  wire logic [bmsa_pkg::SE_W-1:0]            std_error,
    input  wire logic [bmsa_pkg::COUNT_W-1:0]         sample_count,
    input  wire logic                                 error_undefined,
    input  wire logic                                 last,
    output int                                        fail_count,
    output int                                        pending,
    output int                                        report_count,
    output int                                        word_count
);

    localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -64'sh8000_0000_0000;

    typedef struct {
        logic [bmsa_pkg::POS_W-1:0]   position;
        logic [bmsa_pkg::SUM_W-1:0]   mean;
        logic [bmsa_pkg::SE_W-1:0]    std_error;
        logic [bmsa_pkg::COUNT_W-1:0] sample_count;
        logic                         error_undefined;
        logic                         last;
    } bin_report_t;

    bin_report_t report_q[$];

    logic        per_bin_mode;
    logic [15:0] runs;
    logic [6:0]  report_bins;

    longint      acc_sum[NUM_BINS];
    logic [63:0] acc_sq[NUM_BINS];
    logic [31:0] acc_cnt[NUM_BINS];

    int mismatches;
    int checked;
    int words;

    assign fail_count   = mismatches;
    assign report_count = checked;
    assign word_count   = words;

    function automatic logic [31:0] floor_sqrt(input logic [63:0] x);
        logic [31:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--)
        begin
            t = {32'd0, r | (32'd1 << b)};
            if (t * t <= x)
                r = t[31:0];
        end
        return r;
    endfunction

    task automatic clear_all();
        for (int i = 0; i < NUM_BINS; i++)
        begin
            acc_sum[i] = 0;
            acc_sq[i]  = '0;
            acc_cnt[i] = '0;
        end
    endtask

    task automatic add_sample(input int idx, input logic signed [31:0] v);
        longint      sv;
        longint      ns;
        logic [63:0] u;
        logic [63:0] sq;
        logic [64:0] tot;
        sv = v;
        if (idx >= NUM_BINS)
            return;
        ns = acc_sum[idx] + sv;
        if (ns > SUM_MAX)
            ns = SUM_MAX;
        if (ns < SUM_MIN)
            ns = SUM_MIN;
        acc_sum[idx] = ns;
        u = (sv < 0) ? -sv : sv;
        sq = (u * u + 64'h8000) >> 16;
        tot = {1'b0, acc_sq[idx]} + {1'b0, sq};
        acc_sq[idx] = tot[64] ? '1 : tot[63:0];
        if (acc_cnt[idx] != '1)
            acc_cnt[idx] = acc_cnt[idx] + 1;
    endtask

    function automatic bin_report_t bin_statistics(input int i, input logic [31:0] intv);
        bin_report_t  r;
        logic [63:0]  d;
        longint       s;
        longint       avg;
        logic [63:0]  pos;
        logic [127:0] a;
        logic [127:0] q;
        logic [127:0] m;
        logic [127:0] v;
        logic [63:0]  num;
        logic [63:0]  q16;
        d = per_bin_mode ? {32'd0, acc_cnt[i]} : {48'd0, runs};
        s = acc_sum[i];
        avg = 0;
        pos = 64'(i + 1) * {32'd0, intv};
        r.position = pos[bmsa_pkg::POS_W-1:0];
        r.std_error = '0;
        r.sample_count = acc_cnt[i];
        r.error_undefined = (d <= 1);
        r.last = 1'b0;
        if (d == 1)
        begin
            avg = s;
        end
        else if (d > 1)
        begin
            avg = s / longint'(d);
            a = (s < 0) ? 128'(-s) : 128'(s);
            q = (a * a) / {64'd0, d};
            if (q[127:80] != 0)
            begin
                num = '0;
            end
            else
            begin
                q16 = q[79:16];
                num = (acc_sq[i] > q16) ? acc_sq[i] - q16 : '0;
            end
            m = {64'd0, d} * {64'd0, d - 64'd1};
            v = {48'd0, num, 16'd0} / m;
            r.std_error = (v[127:64] != 0) ? '1 : floor_sqrt(v[63:0]);
        end
        r.mean = avg[bmsa_pkg::SUM_W-1:0];
        return r;
    endfunction

    task automatic compare_report();
        bin_report_t e;
        if (report_q.size() == 0)
        begin
            $error("result word with no expectation waiting: position %0h", position);
            mismatches++;
            return;
        end
        e = report_q.pop_front();
        checked++;
        if (position !== e.position)
        begin
            $error("position: expected %0h, got %0h", e.position, position);
            mismatches++;
        end
        if (mean !== e.mean)
        begin
            $error("mean: expected %0h, got %0h", e.mean, mean);
            mismatches++;
        end
        if (std_error !== e.std_error)
        begin
            $error("std_error: expected %0h, got %0h", e.std_error, std_error);
            mismatches++;
        end
        if (sample_count !== e.sample_count)
        begin
            $error("sample_count: expected %0h, got %0h", e.sample_count, sample_count);
            mismatches++;
        end
        if (error_undefined !== e.error_undefined)
        begin
            $error("error_undefined: expected %0b, got %0b", e.error_undefined,
                   error_undefined);
            mismatches++;
        end
        if (last !== e.last)
        begin
            $error("last: expected %0b, got %0b", e.last, last);
            mismatches++;
        end
    endtask

    task automatic accept_word();
        int          n;
        bin_report_t r;
        words++;
        case (command)
            bmsa_pkg::CMD_ADD:
            begin
                add_sample(int'(bin_index), sample_value);
            end
            bmsa_pkg::CMD_READOUT:
            begin
                n = (report_bins > NUM_BINS) ? NUM_BINS : int'(report_bins);
                for (int i = 0; i < n; i++)
                begin
                    r = bin_statistics(i, interval);
                    r.last = (i == n - 1);
                    report_q = {report_q, r};
                end
                clear_all();
            end
            bmsa_pkg::CMD_CLEAR:
            begin
                clear_all();
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_bin_mode = 1'b0;
            runs = 16'd1;
            report_bins = 7'd64;
            clear_all();
            report_q.delete();
            mismatches = 0;
            checked = 0;
            words = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    bmsa_pkg::REG_DIVISOR_MODE: per_bin_mode = cfg_data[0];
                    bmsa_pkg::REG_RUN_COUNT:    runs = cfg_data[15:0];
                    bmsa_pkg::REG_BINS_IN_USE:  report_bins = cfg_data[6:0];
                    default:                    ;
                endcase
            end
            if (out_valid && out_ready)
                compare_report();
            if (in_valid && in_ready)
                accept_word();
            pending = report_q.size();
        end
    end

endmodule

`default_nettype wire

/* test/tb_binned_mean_stderr_accumulator_top.sv */
`default_nettype none

module tb_binned_mean_stderr_accumulator_top;

    localparam int LIMIT_CYCLES = 25000000;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_write_en;
    logic [bmsa_pkg::CFG_IDX_W-1:0]      cfg_index;
    logic [bmsa_pkg::CFG_W-1:0]          cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic [1:0]                          command;
    logic [5:0]                          bin_index;
    logic signed [bmsa_pkg::VALUE_W-1:0] sample_value;
    logic [31:0]                         interval;
    logic                                out_valid;
    logic                                out_ready;
    logic [bmsa_pkg::POS_W-1:0]          position;
    logic signed [bmsa_pkg::SUM_W-1:0]   mean;
    logic [bmsa_pkg::SE_W-1:0]           std_error;
    logic [bmsa_pkg::COUNT_W-1:0]        sample_count;
    logic                                error_undefined;
    logic                                last;

    int  fail_count;
    int  pending;
    int  report_count;
    int  word_count;
    int  cycles;
    logic calm;
    logic [6:0] bins_setting;

    binned_mean_stderr_accumulator_top u_top (.*);

    bmsa_scoreboard u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT_CYCLES)
            begin
                $display("tb_binned_mean_stderr_accumulator_top failed");
                $finish;
            end
        end
    end

    // Result side: random stalls, one long hold-off on the first readout word.
    initial
    begin
        int  hold;
        bit  held;
        hold = 0;
        held = 0;
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && out_valid)
            begin
                held = 1;
                hold = 2000;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= calm || ($urandom_range(99) >= 16);
            end
        end
    end

    task automatic send_word(input logic [1:0] cmd, input logic [5:0] idx,
                             input logic [31:0] value, input logic [31:0] intv);
        int gap;
        gap = (!calm && $urandom_range(99) < 16) ? $urandom_range(1, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        bin_index    <= idx;
        sample_value <= value;
        interval     <= intv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Lowers valid in the step of the last acceptance, waits for an idle block, then writes the register.
    task automatic write_register(input logic [bmsa_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [15:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || !in_ready)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        if (idx == bmsa_pkg::REG_BINS_IN_USE)
            bins_setting = value[6:0];
    endtask

    function automatic logic [31:0] random_sample();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return $urandom_range(1, 8) % 2 ? 32'h8000_0000 : 32'h7FFF_FFFF;
            default: return 32'($signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
        endcase
    endfunction

    initial
    begin
        int          sent;
        int          phase;
        int          span;
        logic [5:0]  idx;
        logic [15:0] runs;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        command = bmsa_pkg::CMD_ADD;
        bin_index = '0;
        sample_value = '0;
        interval = '0;
        calm = 1'b0;
        bins_setting = 7'd64;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting at reset settings: fixed divisor of one, all 64 bins.
        send_word(bmsa_pkg::CMD_ADD, 6'd0, 32'h7FFF_FFFF, 32'd0);
        send_word(bmsa_pkg::CMD_ADD, 6'd0, 32'h7FFF_FFFF, 32'd0);
        send_word(bmsa_pkg::CMD_ADD, 6'd63, 32'h8000_0000, 32'd0);
        send_word(bmsa_pkg::CMD_ADD, 6'd5, 32'h0000_0000, 32'd0);
        send_word(bmsa_pkg::CMD_UNUSED, 6'd1, 32'h1234_5678, 32'hFFFF_FFFF);
        send_word(bmsa_pkg::CMD_READOUT, 6'd0, 32'd0, 32'hFFFF_FFFF);
        send_word(bmsa_pkg::CMD_ADD, 6'd2, 32'h0001_0000, 32'd0);
        send_word(bmsa_pkg::CMD_CLEAR, 6'd0, 32'd0, 32'd0);
        write_register(bmsa_pkg::REG_DIVISOR_MODE, 16'd1);
        write_register(bmsa_pkg::REG_BINS_IN_USE, 16'd4);
        send_word(bmsa_pkg::CMD_ADD, 6'd1, 32'h0003_0000, 32'd0);
        send_word(bmsa_pkg::CMD_ADD, 6'd2, 32'h0002_0000, 32'd0);
        send_word(bmsa_pkg::CMD_ADD, 6'd2, 32'hFFFF_0000, 32'd0);
        send_word(bmsa_pkg::CMD_ADD, 6'd3, 32'h8000_0000, 32'd0);
        send_word(bmsa_pkg::CMD_ADD, 6'd3, 32'h7FFF_FFFF, 32'd0);
        send_word(bmsa_pkg::CMD_ADD, 6'd3, 32'h8000_0000, 32'd0);
        send_word(bmsa_pkg::CMD_READOUT, 6'd0, 32'd0, 32'h0001_8000);
        write_register(bmsa_pkg::REG_BINS_IN_USE, 16'd0);
        send_word(bmsa_pkg::CMD_ADD, 6'd0, 32'h0000_0001, 32'd0);
        send_word(bmsa_pkg::CMD_READOUT, 6'd0, 32'd0, 32'h0000_0001);
        write_register(bmsa_pkg::REG_BINS_IN_USE, 16'd127);
        write_register(bmsa_pkg::REG_DIVISOR_MODE, 16'd0);
        write_register(bmsa_pkg::REG_RUN_COUNT, 16'hFFFF);
        send_word(bmsa_pkg::CMD_ADD, 6'd63, 32'h7FFF_FFFF, 32'd0);
        send_word(bmsa_pkg::CMD_READOUT, 6'd0, 32'd0, 32'h5555_AAAA);

        // Random part in phases, each with its own settings.
        sent = 0;
        phase = 0;
        while (sent < 130)
        begin
            write_register(bmsa_pkg::REG_DIVISOR_MODE, 16'($urandom_range(1)));
            case (phase % 5)
                0:       runs = 16'd1;
                1:       runs = 16'hFFFF;
                2:       runs = 16'd2;
                default: runs = 16'($urandom_range(1, 65535));
            endcase
            write_register(bmsa_pkg::REG_RUN_COUNT, runs);
            case (phase % 7)
                3:       write_register(bmsa_pkg::REG_BINS_IN_USE, 16'd64);
                5:       write_register(bmsa_pkg::REG_BINS_IN_USE,
                                        16'($urandom_range(65, 127)));
                6:       write_register(bmsa_pkg::REG_BINS_IN_USE, 16'd0);
                default: write_register(bmsa_pkg::REG_BINS_IN_USE,
                                        16'($urandom_range(1, 8)));
            endcase
            calm = (phase == 2);
            span = (bins_setting == 0 || bins_setting > 8) ? 4 : int'(bins_setting);
            repeat ($urandom_range(12, 24))
            begin
                case ($urandom_range(19))
                    0:
                    begin
                        send_word(bmsa_pkg::CMD_CLEAR, 6'($urandom()), $urandom(),
                                  $urandom());
                        sent++;
                    end
                    1:
                    begin
                        send_word(bmsa_pkg::CMD_UNUSED, 6'($urandom()), $urandom(),
                                  $urandom());
                    end
                    2, 3:
                    begin
                        send_word(bmsa_pkg::CMD_ADD, 6'($urandom()), random_sample(),
                                  $urandom());
                        sent++;
                    end
                    default:
                    begin
                        idx = 6'($urandom_range(span - 1));
                        send_word(bmsa_pkg::CMD_ADD, idx, random_sample(), $urandom());
                        sent++;
                    end
                endcase
            end
            send_word(bmsa_pkg::CMD_READOUT, 6'($urandom()), $urandom(), $urandom());
            sent++;
            phase++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 || !in_ready)
            @(posedge clk);
        repeat (1000) @(posedge clk);

        $display("Sent %0d words over %0d setting phases; checked %0d bin reports.",
                 word_count, phase, report_count);
        if (fail_count == 0)
            $display("tb_binned_mean_stderr_accumulator_top passed");
        else
            $display("tb_binned_mean_stderr_accumulator_top failed");
        $finish;
    end

endmodule

`default_nettype wire
